// ----- hdl/tmlw_pkg.sv -----
// ----------------------------------------------------------------------------
// tmlw_pkg: shared types and constants of the mip chain layout walker
// Sequencer states, multiplier operand selects, the control word passed from
// the sequencer to the datapath, and the codes of registers, classes and status.
// ----------------------------------------------------------------------------
package tmlw_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_SLICE,
        S_ADJ,
        S_MLO,
        S_MHI,
        S_ADD,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        MS_ROW,
        MS_SLICE,
        MS_LO,
        MS_HI
    } t_msel;

    typedef struct packed {
        logic  ready;
        t_msel msel;
        logic  ld_row;
        logic  ld_slc;
        logic  acc_lo;
        logic  acc_hi;
        logic  fin;
    } t_ctrl;

    // register indexes
    localparam logic [2:0] CFG_BASE_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_BASE_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_BASE_DEPTH  = 3'd2;
    localparam logic [2:0] CFG_MIP_COUNT   = 3'd3;
    localparam logic [2:0] CFG_ARRAY_SIZE  = 3'd4;
    localparam logic [2:0] CFG_FORMAT      = 3'd5;
    localparam logic [2:0] CFG_UNIT_SIZE   = 3'd6;
    localparam logic [2:0] CFG_MAX_DIM     = 3'd7;

    // format classes
    localparam logic [2:0] FC_PLAIN  = 3'd0;
    localparam logic [2:0] FC_BC     = 3'd1;
    localparam logic [2:0] FC_PACKED = 3'd2;
    localparam logic [2:0] FC_PLANAR = 3'd3;
    localparam logic [2:0] FC_NV11   = 3'd4;

    // actions
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_NEXT  = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OVERRUN = 2'd1;
    localparam logic [1:0] ST_NODATA  = 2'd2;
    localparam logic [1:0] ST_IDLE    = 2'd3;

    localparam logic [18:0] ROW_MAX    = '1;
    localparam logic [33:0] SLICE_MAX  = '1;
    localparam logic [40:0] OFFSET_MAX = '1;

endpackage

// ----- hdl/texture_mip_chain_layout_walker_top.sv -----
// One input beat steps the walk by one mip level and yields one result beat.
// The next input beat is taken only once the level is finished; the result
// is set by four passes through the single 24 x 16 multiplier (row pitch,
// slice pitch, low and high half of slice times depth) plus planar adjust,
// offset sum and the final update. A continue while no walk runs skips the
// arithmetic and goes straight to the final update. Input is taken only in
// idle; a finished result waits in the output register, and the final
// update of the next level waits until that result has been taken.
// ----------------------------------------------------------------------------
// texture_mip_chain_layout_walker_top: mip chain pitch and offset walker
// Computes row pitch, slice pitch and byte offset of each mip level of each
// array item, decides which levels fit the size limit, and flags the end of
// the walk, buffer overrun and empty results.
// ----------------------------------------------------------------------------
module texture_mip_chain_layout_walker_top #(
    parameter int MAX_MIP_LEVELS  = 15,
    parameter int MAX_ARRAY_ITEMS = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [39:0] i_buffer_byte_count,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [14:0] o_subresource_index,
    output logic [10:0] o_array_index,
    output logic [3:0]  o_mip_level,
    output logic [39:0] o_data_offset,
    output logic [18:0] o_row_pitch,
    output logic [33:0] o_slice_pitch,
    output logic        o_kept,
    output logic [3:0]  o_skipped_count,
    output logic [11:0] o_first_depth,
    output logic [1:0]  o_status,
    output logic        o_last
);

    localparam logic [4:0]  L_MAX_MIPS  = 5'(MAX_MIP_LEVELS);
    localparam logic [12:0] L_MAX_ITEMS = 13'(MAX_ARRAY_ITEMS);

    // configuration
    logic [14:0] r_base_w;
    logic [14:0] r_base_h;
    logic [11:0] r_base_d;
    logic [3:0]  r_mip_cnt;
    logic [11:0] r_arr_size;
    logic [2:0]  r_fmt;
    logic [7:0]  r_unit;
    logic [14:0] r_max_dim;

    // walk state
    logic [14:0] r_lvl_w;
    logic [14:0] r_lvl_h;
    logic [11:0] r_lvl_d;
    logic [3:0]  r_mpos;
    logic [11:0] r_apos;
    logic [40:0] r_off;
    logic [39:0] r_blim;
    logic [16:0] r_kept;
    logic [3:0]  r_skip;
    logic [11:0] r_dof;
    logic        r_done;
    logic        r_idle;

    // per-level working registers
    logic [21:0] r_row;
    logic [37:0] r_slc;
    logic [51:0] r_acc;

    // result register
    logic        r_ovld;
    logic [14:0] r_o_sub;
    logic [10:0] r_o_arr;
    logic [3:0]  r_o_mip;
    logic [39:0] r_o_off;
    logic [18:0] r_o_row;
    logic [33:0] r_o_slc;
    logic        r_o_kept;
    logic [3:0]  r_o_skip;
    logic [11:0] r_o_fdep;
    logic [1:0]  r_o_stat;
    logic        r_o_last;

    tmlw_pkg::t_ctrl ctrl;
    logic            in_fire;
    logic            idle_cont;
    logic            slot_free;

    logic [23:0] mul_a;
    logic [15:0] mul_b;
    logic [39:0] prod;

    logic [14:0] w;
    logic [14:0] h;
    logic [11:0] d;
    logic [14:0] w_term;
    logic [7:0]  u_term;
    logic [15:0] h_term;
    logic [23:0] plain_sum;
    logic [21:0] row_fix;
    logic [38:0] slc_adj;

    logic [4:0]  eff_mips;
    logic [12:0] eff_items;
    logic        keep;
    logic [16:0] n_kept;
    logic [3:0]  n_skip;
    logic [11:0] n_dof;
    logic [40:0] n_off;
    logic        overrun;
    logic [4:0]  mpos_inc;
    logic [11:0] apos_inc;
    logic        mip_wrap;
    logic        arr_end;
    logic [1:0]  n_stat;
    logic        n_last;

    assign in_fire   = i_in_valid & ctrl.ready;
    assign idle_cont = (i_action == tmlw_pkg::ACT_NEXT) & r_done;
    assign slot_free = ~r_ovld | i_out_ready;

    tmlw_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (in_fire),
        .i_idle_cont (idle_cont),
        .i_slot_free (slot_free),
        .o_ctrl      (ctrl)
    );

    tmlw_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_w   <= 15'd1;
            r_base_h   <= 15'd1;
            r_base_d   <= 12'd1;
            r_mip_cnt  <= 4'd1;
            r_arr_size <= 12'd1;
            r_fmt      <= tmlw_pkg::FC_PLAIN;
            r_unit     <= 8'd32;
            r_max_dim  <= 15'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tmlw_pkg::CFG_BASE_WIDTH:  r_base_w   <= i_cfg_data;
                tmlw_pkg::CFG_BASE_HEIGHT: r_base_h   <= i_cfg_data;
                tmlw_pkg::CFG_BASE_DEPTH:  r_base_d   <= i_cfg_data[11:0];
                tmlw_pkg::CFG_MIP_COUNT:   r_mip_cnt  <= i_cfg_data[3:0];
                tmlw_pkg::CFG_ARRAY_SIZE:  r_arr_size <= i_cfg_data[11:0];
                tmlw_pkg::CFG_FORMAT:      r_fmt      <= i_cfg_data[2:0];
                tmlw_pkg::CFG_UNIT_SIZE:   r_unit     <= i_cfg_data[7:0];
                tmlw_pkg::CFG_MAX_DIM:     r_max_dim  <= i_cfg_data;
                default:                   r_max_dim  <= r_max_dim;
            endcase
        end
    end

    // level dimensions, raised to at least 1
    assign w = (r_lvl_w == 15'd0) ? 15'd1 : r_lvl_w;
    assign h = (r_lvl_h == 15'd0) ? 15'd1 : r_lvl_h;
    assign d = (r_lvl_d == 12'd0) ? 12'd1 : r_lvl_d;

    // multiplier operands by format class
    always_comb begin
        w_term = w;
        u_term = r_unit;
        h_term = 16'(h);
        case (r_fmt)
            tmlw_pkg::FC_BC: begin
                w_term = 15'((16'(w) + 16'd3) >> 2);
                h_term = (16'(h) + 16'd3) >> 2;
            end
            tmlw_pkg::FC_PACKED, tmlw_pkg::FC_PLANAR: begin
                w_term = 15'((16'(w) + 16'd1) >> 1);
            end
            tmlw_pkg::FC_NV11: begin
                w_term = 15'((16'(w) + 16'd3) >> 2);
                u_term = 8'd4;
                h_term = {h, 1'b0};
            end
            default: begin
                w_term = w;
            end
        endcase
    end

    // plain rows round bits up to bytes
    assign plain_sum = 24'(prod[22:0]) + 24'd7;

    always_comb begin
        case (r_fmt)
            tmlw_pkg::FC_BC, tmlw_pkg::FC_PACKED,
            tmlw_pkg::FC_PLANAR, tmlw_pkg::FC_NV11: row_fix = prod[21:0];
            default:                                row_fix = 22'(plain_sum[23:3]);
        endcase
    end

    always_comb begin
        case (ctrl.msel)
            tmlw_pkg::MS_ROW: begin
                mul_a = 24'(w_term);
                mul_b = 16'(u_term);
            end
            tmlw_pkg::MS_SLICE: begin
                mul_a = 24'(row_fix);
                mul_b = h_term;
            end
            tmlw_pkg::MS_LO: begin
                mul_a = r_slc[23:0];
                mul_b = 16'(d);
            end
            tmlw_pkg::MS_HI: begin
                mul_a = 24'(r_slc[37:24]);
                mul_b = 16'(d);
            end
            default: begin
                mul_a = 24'(w_term);
                mul_b = 16'(u_term);
            end
        endcase
    end

    // planar adds half a plane again for chroma
    assign slc_adj = (r_fmt == tmlw_pkg::FC_PLANAR)
                   ? 39'(prod[37:0]) + ((39'(prod[37:0]) + 39'd1) >> 1)
                   : 39'(prod[37:0]);

    always_ff @(posedge i_clk) begin
        if (ctrl.ld_row) begin
            r_row <= row_fix;
        end
        if (ctrl.ld_slc) begin
            r_slc <= slc_adj[37:0];
        end
        if (ctrl.acc_lo) begin
            r_acc <= 52'(r_off) + 52'(prod[35:0]);
        end else if (ctrl.acc_hi) begin
            r_acc <= r_acc + {2'b00, prod[25:0], 24'd0};
        end
    end

    // level decision and next walk state
    always_comb begin
        eff_mips  = (r_mip_cnt == 4'd0) ? 5'd1 : {1'b0, r_mip_cnt};
        if (eff_mips > L_MAX_MIPS) begin
            eff_mips = L_MAX_MIPS;
        end
        eff_items = (r_arr_size == 12'd0) ? 13'd1 : {1'b0, r_arr_size};
        if (eff_items > L_MAX_ITEMS) begin
            eff_items = L_MAX_ITEMS;
        end

        keep = (eff_mips <= 5'd1) || (r_max_dim == 15'd0) ||
               ((w <= r_max_dim) && (h <= r_max_dim) && (15'(d) <= r_max_dim));

        n_kept = r_kept + (keep ? 17'd1 : 17'd0);
        n_skip = r_skip;
        if (!keep && (r_apos == 12'd0) && (r_skip != 4'hF)) begin
            n_skip = r_skip + 4'd1;
        end
        n_dof = (keep && (r_dof == 12'd0)) ? d : r_dof;

        n_off   = (r_acc > 52'(tmlw_pkg::OFFSET_MAX)) ? tmlw_pkg::OFFSET_MAX
                                                      : r_acc[40:0];
        overrun = n_off > {1'b0, r_blim};

        mpos_inc = {1'b0, r_mpos} + 5'd1;
        apos_inc = r_apos + 12'd1;
        mip_wrap = mpos_inc >= eff_mips;
        arr_end  = mip_wrap && ({1'b0, apos_inc} >= eff_items);

        n_stat = tmlw_pkg::ST_OK;
        n_last = 1'b0;
        if (overrun) begin
            n_stat = tmlw_pkg::ST_OVERRUN;
            n_last = 1'b1;
        end else if (arr_end) begin
            n_stat = (n_kept == 17'd0) ? tmlw_pkg::ST_NODATA : tmlw_pkg::ST_OK;
            n_last = 1'b1;
        end
    end

    // walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b1;
            r_idle <= 1'b0;
        end else if (in_fire) begin
            r_idle <= idle_cont;
            if (i_action == tmlw_pkg::ACT_START) begin
                r_done <= 1'b0;
            end
        end else if (ctrl.fin && !r_idle && (overrun || arr_end)) begin
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && (i_action == tmlw_pkg::ACT_START)) begin
            r_blim  <= i_buffer_byte_count;
            r_off   <= '0;
            r_kept  <= '0;
            r_skip  <= '0;
            r_dof   <= '0;
            r_mpos  <= '0;
            r_apos  <= '0;
            r_lvl_w <= r_base_w;
            r_lvl_h <= r_base_h;
            r_lvl_d <= r_base_d;
        end else if (ctrl.fin && !r_idle) begin
            r_kept <= n_kept;
            r_skip <= n_skip;
            r_dof  <= n_dof;
            r_off  <= n_off;
            if (!overrun) begin
                if (mip_wrap) begin
                    // next array item starts again at the base level
                    r_mpos  <= '0;
                    r_apos  <= apos_inc;
                    r_lvl_w <= r_base_w;
                    r_lvl_h <= r_base_h;
                    r_lvl_d <= r_base_d;
                end else begin
                    r_mpos  <= mpos_inc[3:0];
                    r_lvl_w <= w >> 1;
                    r_lvl_h <= h >> 1;
                    r_lvl_d <= d >> 1;
                end
            end
        end
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (ctrl.fin) begin
            r_ovld <= 1'b1;
        end else if (i_out_ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.fin) begin
            if (r_idle) begin
                r_o_sub  <= '0;
                r_o_arr  <= '0;
                r_o_mip  <= '0;
                r_o_off  <= '0;
                r_o_row  <= '0;
                r_o_slc  <= '0;
                r_o_kept <= 1'b0;
                r_o_skip <= '0;
                r_o_fdep <= '0;
                r_o_stat <= tmlw_pkg::ST_IDLE;
                r_o_last <= 1'b0;
            end else begin
                r_o_sub  <= r_kept[14:0];
                r_o_arr  <= r_apos[10:0];
                r_o_mip  <= r_mpos;
                r_o_off  <= r_off[39:0];
                r_o_row  <= (r_row > 22'(tmlw_pkg::ROW_MAX)) ? tmlw_pkg::ROW_MAX
                                                             : r_row[18:0];
                r_o_slc  <= (r_slc > 38'(tmlw_pkg::SLICE_MAX)) ? tmlw_pkg::SLICE_MAX
                                                               : r_slc[33:0];
                r_o_kept <= keep;
                r_o_skip <= n_skip;
                r_o_fdep <= n_dof;
                r_o_stat <= n_stat;
                r_o_last <= n_last;
            end
        end
    end

    assign o_in_ready          = ctrl.ready;
    assign o_out_valid         = r_ovld;
    assign o_subresource_index = r_o_sub;
    assign o_array_index       = r_o_arr;
    assign o_mip_level         = r_o_mip;
    assign o_data_offset       = r_o_off;
    assign o_row_pitch         = r_o_row;
    assign o_slice_pitch       = r_o_slc;
    assign o_kept              = r_o_kept;
    assign o_skipped_count     = r_o_skip;
    assign o_first_depth       = r_o_fdep;
    assign o_status            = r_o_stat;
    assign o_last              = r_o_last;

endmodule

// ----- hdl/tmlw_mul.sv -----
// ----------------------------------------------------------------------------
// tmlw_mul: shared 24 x 16 multiplier
// Unsigned product, registered; one product per cycle.
// ----------------------------------------------------------------------------
module tmlw_mul (
    input  logic        i_clk,
    input  logic [23:0] i_a,
    input  logic [15:0] i_b,
    output logic [39:0] o_prod
);

    logic [39:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 40'(i_a) * 40'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ----- hdl/tmlw_seq.sv -----
// ----------------------------------------------------------------------------
// tmlw_seq: level sequencer
// Steps one level through row pitch, slice pitch, planar adjust, the two halves
// of slice times depth, offset sum and final update; idle continue goes to the end.
// ----------------------------------------------------------------------------
module tmlw_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_fire,
    input  logic            i_idle_cont,
    input  logic            i_slot_free,
    output tmlw_pkg::t_ctrl o_ctrl
);

    tmlw_pkg::t_state r_state;
    tmlw_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tmlw_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tmlw_pkg::S_IDLE: begin
                if (i_in_fire) begin
                    // idle continue needs no arithmetic
                    n_state = i_idle_cont ? tmlw_pkg::S_FIN : tmlw_pkg::S_ROW;
                end
            end
            tmlw_pkg::S_ROW:   n_state = tmlw_pkg::S_SLICE;
            tmlw_pkg::S_SLICE: n_state = tmlw_pkg::S_ADJ;
            tmlw_pkg::S_ADJ:   n_state = tmlw_pkg::S_MLO;
            tmlw_pkg::S_MLO:   n_state = tmlw_pkg::S_MHI;
            tmlw_pkg::S_MHI:   n_state = tmlw_pkg::S_ADD;
            tmlw_pkg::S_ADD:   n_state = tmlw_pkg::S_FIN;
            tmlw_pkg::S_FIN: begin
                if (i_slot_free) begin
                    n_state = tmlw_pkg::S_IDLE;
                end
            end
            default: n_state = tmlw_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl        = '0;
        o_ctrl.msel   = tmlw_pkg::MS_ROW;
        case (r_state)
            tmlw_pkg::S_IDLE:  o_ctrl.ready = 1'b1;
            tmlw_pkg::S_ROW:   o_ctrl.msel  = tmlw_pkg::MS_ROW;
            tmlw_pkg::S_SLICE: begin
                o_ctrl.msel   = tmlw_pkg::MS_SLICE;
                o_ctrl.ld_row = 1'b1;
            end
            tmlw_pkg::S_ADJ:   o_ctrl.ld_slc = 1'b1;
            tmlw_pkg::S_MLO:   o_ctrl.msel   = tmlw_pkg::MS_LO;
            tmlw_pkg::S_MHI: begin
                o_ctrl.msel   = tmlw_pkg::MS_HI;
                o_ctrl.acc_lo = 1'b1;
            end
            tmlw_pkg::S_ADD:   o_ctrl.acc_hi = 1'b1;
            tmlw_pkg::S_FIN:   o_ctrl.fin    = i_slot_free;
            default:           o_ctrl.ready  = 1'b0;
        endcase
    end

endmodule
